// File: hdl/tshs_pkg.sv
package tshs_pkg;

   // Defaults for the top-level parameters
   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF = 16;

   // Control registers
   localparam int REG_BITS = 16;
   localparam int IDX_BITS = 2;

   localparam logic [IDX_BITS-1:0] REG_FILTER_COEF   = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_FIRST_THRESH  = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_SECOND_THRESH = 2'd2;

   localparam logic [REG_BITS-1:0] FILTER_COEF_RST   = 16'd65468;
   localparam logic [REG_BITS-1:0] FIRST_THRESH_RST  = 16'd983;
   localparam logic [REG_BITS-1:0] SECOND_THRESH_RST = 16'd3932;

   typedef struct packed {
      logic [REG_BITS-1:0] filter_coef;
      logic [REG_BITS-1:0] first_thresh;
      logic [REG_BITS-1:0] second_thresh;
   } csr_type;

endpackage

// File: hdl/tshs_core.sv
module tshs_core
   import tshs_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  csr_type                       csr,
   output logic                          ppi_level,
   output logic signed [SAMPLE_BITS+1:0] filtered_value
);

   localparam int OUT_BITS  = SAMPLE_BITS + 2;
   localparam int SUM_BITS  = SAMPLE_BITS + 3;
   localparam int PROD_BITS = SUM_BITS + REG_BITS + 1;
   localparam int CMP_BITS  = ((OUT_BITS > REG_BITS) ? OUT_BITS : REG_BITS) + 2;

   localparam logic signed [PROD_BITS-1:0] OUT_MAX = PROD_BITS'(2**(OUT_BITS-1) - 1);
   localparam logic signed [PROD_BITS-1:0] OUT_MIN = PROD_BITS'(-(2**(OUT_BITS-1)));
   localparam logic signed [CMP_BITS-1:0]  FULL_SCALE = CMP_BITS'(2**(SAMPLE_BITS-1));

   logic signed [SAMPLE_BITS-1:0] prev_sample_ff;
   logic signed [OUT_BITS-1:0]    prev_output_ff;
   logic                          first_level_ff;
   logic                          second_level_ff;

   logic signed [SUM_BITS-1:0]    sum;
   logic signed [PROD_BITS-1:0]   sum_ext;
   logic signed [PROD_BITS-1:0]   coef_ext;
   logic signed [PROD_BITS-1:0]   prod;
   logic signed [PROD_BITS-1:0]   shifted;
   logic signed [OUT_BITS-1:0]    y;
   logic signed [CMP_BITS-1:0]    y_cmp;
   logic signed [CMP_BITS-1:0]    h1_cmp;
   logic signed [CMP_BITS-1:0]    h2_cmp;
   logic                          first_level_in;
   logic                          second_level_in;

   always_comb begin
      sum = SUM_BITS'(prev_output_ff) + SUM_BITS'(sample) - SUM_BITS'(prev_sample_ff);
      sum_ext  = PROD_BITS'(sum);
      coef_ext = signed'({{(PROD_BITS-REG_BITS){1'b0}}, csr.filter_coef});
      prod     = sum_ext * coef_ext;
      // arithmetic shift floors toward minus infinity
      shifted  = prod >>> COEF_FRAC_BITS;
      if (shifted > OUT_MAX) begin
         y = OUT_MAX[OUT_BITS-1:0];
      end else if (shifted < OUT_MIN) begin
         y = OUT_MIN[OUT_BITS-1:0];
      end else begin
         y = shifted[OUT_BITS-1:0];
      end
   end

   always_comb begin
      y_cmp  = CMP_BITS'(y);
      h1_cmp = signed'({{(CMP_BITS-REG_BITS){1'b0}}, csr.first_thresh});
      h2_cmp = signed'({{(CMP_BITS-REG_BITS){1'b0}}, csr.second_thresh});

      if (y_cmp >= h1_cmp) begin
         first_level_in = 1'b1;
      end else if (y_cmp <= -h1_cmp) begin
         first_level_in = 1'b0;
      end else begin
         first_level_in = first_level_ff;
      end

      // first level swings to full scale: it crosses the band only if the band fits
      if (h2_cmp <= FULL_SCALE) begin
         second_level_in = first_level_in;
      end else begin
         second_level_in = second_level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff  <= '0;
         prev_output_ff  <= '0;
         first_level_ff  <= 1'b1;
         second_level_ff <= 1'b1;
      end else if (advance) begin
         prev_sample_ff  <= sample;
         prev_output_ff  <= y;
         first_level_ff  <= first_level_in;
         second_level_ff <= second_level_in;
      end
   end

   assign ppi_level      = second_level_in;
   assign filtered_value = y;

   a_second_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && h2_cmp > FULL_SCALE) |=> $stable(second_level_ff))
      else $error("second level moved with threshold above full scale");

   a_second_copies: assert property (@(posedge clock) disable iff (reset)
      (advance && csr.second_thresh == '0) |=> (second_level_ff == first_level_ff))
      else $error("second level does not follow first level at zero threshold");

   a_first_sets: assert property (@(posedge clock) disable iff (reset)
      (advance && y_cmp >= h1_cmp) |=> first_level_ff)
      else $error("first level not set above threshold");

endmodule

// File: hdl/tape_signal_highpass_schmitt_slicer_unit.sv
// Tape read slicer: DC-blocking high-pass filter followed by two Schmitt triggers.
// Input channel req_*: one signed audio sample per item in req_tdata.
// Result channel rsp_*: one item per input item, carrying the PPI read level
// and the saturated filter output.
// Control port csr_*: write csr_wdata to register csr_index when csr_we is high;
// index 0 filter coefficient, 1 first threshold, 2 second threshold.
// Write registers only while no item is in flight.
// Path: an accepted item passes the input register, then the result register,
// before it is presented on rsp_*. Throughput: one item per cycle while the
// receiver does not stall; the filter recursion closes through one multiply.
// Reset clears both stages, zeroes the filter history, sets both levels
// positive and loads the register defaults.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; after that req_tready drops until
// rsp_tready returns.
module tape_signal_highpass_schmitt_slicer_unit
   import tshs_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        req_tdata,  // sample
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((SAMPLE_BITS+10)/8)*8-1:0]       rsp_tdata,  // ppi_level, filtered_value
   input  logic                                    csr_we,
   input  logic [IDX_BITS-1:0]                     csr_index,
   input  logic [REG_BITS-1:0]                     csr_wdata
);

   localparam int RSP_BITS = ((SAMPLE_BITS+10)/8)*8;

   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          rsp_valid_ff;
   logic [RSP_BITS-1:0]           rsp_data_ff;
   csr_type                       csr_ff;

   logic                          out_free;
   logic                          advance;
   logic                          ppi_level;
   logic signed [SAMPLE_BITS+1:0] filtered_value;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.filter_coef   <= FILTER_COEF_RST;
         csr_ff.first_thresh  <= FIRST_THRESH_RST;
         csr_ff.second_thresh <= SECOND_THRESH_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_FILTER_COEF:   csr_ff.filter_coef   <= csr_wdata;
            REG_FIRST_THRESH:  csr_ff.first_thresh  <= csr_wdata;
            REG_SECOND_THRESH: csr_ff.second_thresh <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= RSP_BITS'({filtered_value, ppi_level});
      end
   end

   tshs_core #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .sample        (s1_sample_ff),
      .csr           (csr_ff),
      .ppi_level     (ppi_level),
      .filtered_value(filtered_value)
   );

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not reach result register");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted item not held in input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_sample_ff)))
      else $error("input register lost item during stall");

endmodule
